// ===== src/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types, register indexes and constants of the lap split detector.
// ----------------------------------------------------------------------------
package lsd_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int SPLIT_BITS  = 24;
    localparam int GAP_BITS    = 24;
    localparam int RATE_BITS   = 14;
    localparam int MODE_BITS   = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 14;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SPLIT_BITS-1:0]         split_idx_t;
    typedef logic [GAP_BITS-1:0]           gap_cnt_t;
    typedef logic [RATE_BITS-1:0]          rate_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_BEACON     = 2'd0,
        MODE_LAP_TIME   = 2'd1,
        MODE_LAP_NUMBER = 2'd2,
        MODE_DISTANCE   = 2'd3
    } mode_t;

    localparam cfg_idx_t CFG_DETECT_MODE = 1'b0;
    localparam cfg_idx_t CFG_SAMPLE_RATE = 1'b1;

    localparam mode_t    MODE_RESET = MODE_BEACON;
    localparam rate_t    RATE_RESET = 14'd50;
    localparam gap_cnt_t GAP_MAX    = 24'hFFFFFF;

    // Drop thresholds in Q23.8 (5.0 and 300.0)
    localparam logic signed [SAMPLE_BITS:0] LAP_TIME_DROP_Q8 = 33'sd1280;
    localparam logic signed [SAMPLE_BITS:0] DISTANCE_DROP_Q8 = 33'sd76800;

    // Round Q23.8 to integer, half away from zero
    function automatic logic signed [SAMPLE_BITS-8:0] round_q8(input sample_t raw);
        logic signed [SAMPLE_BITS:0] biased;
        biased = $signed({raw[SAMPLE_BITS-1], raw}) + 33'sd128
                 - (raw[SAMPLE_BITS-1] ? 33'sd1 : 33'sd0);
        return biased[SAMPLE_BITS:8];
    endfunction

endpackage

// ===== src/lsd_sample_if.sv =====
// ----------------------------------------------------------------------------
// lsd_sample_if
// Sample request channel: one telemetry sample and its series start flag.
// ----------------------------------------------------------------------------
interface lsd_sample_if
    import lsd_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_value;
    logic    series_start;

    modport source (output valid, output sample_value, output series_start, input ready);
    modport sink   (input valid, input sample_value, input series_start, output ready);
endinterface

// ===== src/lsd_split_if.sv =====
// ----------------------------------------------------------------------------
// lsd_split_if
// Split request channel: sample index of one detected lap split.
// ----------------------------------------------------------------------------
interface lsd_split_if
    import lsd_pkg::*;
();
    logic       valid;
    logic       ready;
    split_idx_t split_index;

    modport source (output valid, output split_index, input ready);
    modport sink   (input valid, input split_index, output ready);
endinterface

// ===== src/lsd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lsd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lsd_cfg_if
    import lsd_pkg::*;
();
    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/lap_split_detector_core.sv =====
// ----------------------------------------------------------------------------
// lap_split_detector_core
// Detects lap splits in a telemetry sample stream and reports their indexes.
// ----------------------------------------------------------------------------
//  channel     dir   handshake      payload
//  sample_in   in    valid/ready    sample_value (s32 Q23.8), series_start
//  split_out   out   valid/ready    split_index (u24)
//  cfg         in    valid/ready    index (1b), data (14b)
//
//  One sample per cycle sustained while split_out does not stall; a split is
//  offered once its sample has passed the input register, then the result register.
//  All judging and state update happen in one pass from the input register.
//  rst_n clears the pipeline, the running state and the registers to their
//  defaults (beacon mode, 50 Hz). A stalled split_out holds the result and
//  the sample in the input register; sample_in stays ready while it is empty.
// ----------------------------------------------------------------------------
module lap_split_detector_core
    import lsd_pkg::*;
#(
    parameter int INDEX_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    lsd_sample_if.sink  sample_in,
    lsd_split_if.source split_out,
    lsd_cfg_if.sink     cfg
);

    typedef logic [INDEX_BITS-1:0] index_t;

    // configuration
    mode_t mode_reg;
    rate_t rate_reg;

    // input register
    logic    s1_valid_reg;
    sample_t s1_value_reg;
    logic    s1_start_reg;

    // running state
    index_t   counter_reg;
    sample_t  prev_reg;
    logic     pulse_reg;
    gap_cnt_t since_reg;
    logic     seen_reg;

    // result register
    logic       out_valid_reg;
    split_idx_t out_index_reg;

    logic advance;
    logic take_in;

    // effective state after a series start
    index_t   cur_idx;
    logic     cur_pulse;
    gap_cnt_t cur_since;
    logic     cur_seen;
    logic     first;

    logic                          active;
    logic signed [SAMPLE_BITS-8:0] rnd_cur;
    logic signed [SAMPLE_BITS-8:0] rnd_prev;
    logic signed [SAMPLE_BITS:0]   drop;
    logic [RATE_BITS-2:0]          gap;
    gap_cnt_t                      gap_dist;
    logic                          gap_ok;
    logic                          split;
    logic [31:0]                   idx_wide;

    index_t   counter_next;
    gap_cnt_t since_next;

    assign advance = s1_valid_reg && (!out_valid_reg || split_out.ready);
    assign take_in = sample_in.valid && sample_in.ready;

    assign sample_in.ready = !s1_valid_reg || advance;
    assign cfg.ready       = 1'b1;

    assign split_out.valid       = out_valid_reg;
    assign split_out.split_index = out_index_reg;

    always_comb
    begin
        cur_idx   = s1_start_reg ? '0   : counter_reg;
        cur_pulse = s1_start_reg ? 1'b0 : pulse_reg;
        cur_since = s1_start_reg ? '0   : since_reg;
        cur_seen  = s1_start_reg ? 1'b0 : seen_reg;
        first     = (cur_idx == '0);

        rnd_cur  = round_q8(s1_value_reg);
        rnd_prev = round_q8(prev_reg);
        active   = (rnd_cur != '0);

        drop = $signed({prev_reg[SAMPLE_BITS-1], prev_reg})
             - $signed({s1_value_reg[SAMPLE_BITS-1], s1_value_reg});

        gap  = (rate_reg[RATE_BITS-1:1] == '0) ? (RATE_BITS-1)'(1) : rate_reg[RATE_BITS-1:1];
        gap_dist = (cur_since == GAP_MAX) ? cur_since : cur_since + 1'b1;
        gap_ok = !cur_seen || (gap_dist >= GAP_BITS'(gap));

        case (mode_reg)
            MODE_BEACON:     split = active && !cur_pulse;
            MODE_LAP_NUMBER: split = !first && (rnd_cur > rnd_prev);
            MODE_LAP_TIME:   split = !first && (drop > LAP_TIME_DROP_Q8) && gap_ok;
            MODE_DISTANCE:   split = !first && (drop > DISTANCE_DROP_Q8) && gap_ok;
            default:         split = 1'b0;
        endcase

        if (split)
            since_next = '0;
        else if (!first)
            since_next = gap_dist;
        else
            since_next = cur_since;

        // saturate the index at all ones
        counter_next = (cur_idx == '1) ? cur_idx : cur_idx + 1'b1;
        idx_wide     = 32'(cur_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            rate_reg      <= RATE_RESET;
            s1_valid_reg  <= 1'b0;
            counter_reg   <= '0;
            prev_reg      <= '0;
            pulse_reg     <= 1'b0;
            since_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_DETECT_MODE: mode_reg <= mode_t'(cfg.data[MODE_BITS-1:0]);
                    CFG_SAMPLE_RATE: rate_reg <= cfg.data[RATE_BITS-1:0];
                    default: ;
                endcase
            end

            // load the input register, drop it once judged
            if (take_in)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                counter_reg <= counter_next;
                prev_reg    <= s1_value_reg;
                pulse_reg   <= active;
                since_reg   <= since_next;
                seen_reg    <= cur_seen || split;
            end

            if (advance)
                out_valid_reg <= split;
            else if (split_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_value_reg <= sample_in.sample_value;
            s1_start_reg <= sample_in.series_start;
        end
        if (advance && split)
            out_index_reg <= idx_wide[SPLIT_BITS-1:0];
    end

    // a result only ever comes from a judged sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("split result without a judged sample");

    // a reported split restarts the gap count
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && split) |=> (since_reg == '0) && seen_reg)
        else $error("gap count not restarted after split");

    // the index only moves back on a series start
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_start_reg) |=> (counter_reg >= $past(counter_reg)))
        else $error("sample index went backward");

    // an empty input register always takes a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample_in.ready)
        else $error("input stalled while empty");

endmodule
